/* rtl/fed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_pkg - shared types and constants of the flag/escape deframer
// Byte codes, phase and status codes, and the per-frame state record.
// ----------------------------------------------------------------------------
package fed_pkg;

	localparam logic [7:0] FLAG_BYTE    = 8'h7e;
	localparam logic [7:0] ESC_BYTE     = 8'h7d;
	localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
	localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
	localparam logic [7:0] MIN_LEN_RESET = 8'd11;
	localparam logic [7:0] RAW_COUNT_MAX = 8'hff;

	// frame phase; code 3 never occurs and behaves as hunting
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_ESC  = 2'd2;

	// status of the final byte of a frame
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_XOR     = 2'd1;
	localparam logic [1:0] STAT_BAD_ESC = 2'd2;
	localparam logic [1:0] STAT_SHORT   = 2'd3;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] raw_count;
		logic [7:0] held_byte;
		logic       held_valid;
		logic [7:0] xor_acc;
		logic       escape_error;
	} frame_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [1:0] status;
	} result_t;

endpackage

/* rtl/fed_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_in_if - raw byte channel
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface fed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

/* rtl/fed_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_out_if - deframed byte channel
// Valid/ready channel carrying one body byte with last and status.
// ----------------------------------------------------------------------------
interface fed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [1:0] status;

	modport source (output valid, output out_byte, output last, output status, input ready);
	modport sink (input valid, input out_byte, input last, input status, output ready);
endinterface

/* rtl/fed_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_step - per-byte deframing logic
// Next frame state and optional result for one raw byte.
// ----------------------------------------------------------------------------
module fed_step
	import fed_pkg::*;
(
	input  frame_state_t cur,
	input  logic [7:0]   raw_byte,
	input  logic [7:0]   min_len,
	output frame_state_t nxt,
	output logic         res_valid,
	output result_t      res
);

	logic       in_frame;
	logic [7:0] cnt_inc;
	logic [7:0] body_byte;
	logic       take_body;

	assign in_frame = (cur.phase == PH_BODY) || (cur.phase == PH_ESC);
	assign cnt_inc  = (cur.raw_count == RAW_COUNT_MAX) ? cur.raw_count
	                                                   : cur.raw_count + 8'd1;

	always_comb begin
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		body_byte = raw_byte;
		take_body = 1'b0;

		if (!in_frame) begin
			if (raw_byte == FLAG_BYTE) begin
				nxt           = '0;
				nxt.phase     = PH_BODY;
				nxt.raw_count = 8'd1;
			end
		end else if (raw_byte == FLAG_BYTE) begin
			nxt = '0;
			if (!cur.held_valid) begin
				// doubled flag: restart the frame
				nxt.phase     = PH_BODY;
				nxt.raw_count = 8'd1;
			end else begin
				nxt.phase    = PH_HUNT;
				res_valid    = 1'b1;
				res.out_byte = cur.held_byte;
				res.last     = 1'b1;
				if (cur.escape_error || cur.phase == PH_ESC)
					res.status = STAT_BAD_ESC;
				else if (cnt_inc < min_len)
					res.status = STAT_SHORT;
				else if (cur.xor_acc != cur.held_byte)
					res.status = STAT_XOR;
				else
					res.status = STAT_OK;
			end
		end else begin
			nxt.raw_count = cnt_inc;
			if (cur.phase == PH_ESC) begin
				nxt.phase = PH_BODY;
				if (raw_byte == ESC_FOR_ESC) begin
					body_byte = ESC_BYTE;
					take_body = 1'b1;
				end else if (raw_byte == ESC_FOR_FLAG) begin
					body_byte = FLAG_BYTE;
					take_body = 1'b1;
				end else begin
					nxt.escape_error = 1'b1;
				end
			end else if (raw_byte == ESC_BYTE) begin
				nxt.phase = PH_ESC;
			end else begin
				take_body = 1'b1;
			end

			if (take_body) begin
				// release the held byte, hold the new one
				if (cur.held_valid) begin
					res_valid    = 1'b1;
					res.out_byte = cur.held_byte;
					nxt.xor_acc  = cur.xor_acc ^ cur.held_byte;
				end
				nxt.held_byte  = body_byte;
				nxt.held_valid = 1'b1;
			end
		end
	end

endmodule

/* rtl/flag_escape_deframer_xor_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flag_escape_deframer_xor_check - flag-framed byte deframer with XOR check
// Hunts 0x7e flags, removes 0x7d escapes, delays body bytes by one so the
// closing flag can tag the check byte with last and a frame status.
// ----------------------------------------------------------------------------
//
//  channel        dir   payload                     transaction
//  in_ch          in    in_byte[7:0]                valid & ready
//  out_ch         out   out_byte[7:0] last status   valid & ready
//  min_frame_len  in    min_frame_len_wdata[7:0]    min_frame_len_we
//
//  One raw byte per cycle sustained while out_ch takes results. A byte is
//  captured in the input register, then the step logic updates frame state
//  and loads the result register when the byte produces a result.
//  arst_n clears all control state and restores min_frame_len to 11.
//  A stall on out_ch stops the input register only when it holds a byte
//  that produces a result; bytes with no result keep flowing.
//
module flag_escape_deframer_xor_check
	import fed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fed_in_if.sink      in_ch,
	fed_out_if.source   out_ch,
	input  logic        min_frame_len_we,
	input  logic [7:0]  min_frame_len_wdata
);

	// configuration
	logic [7:0] min_len_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state
	frame_state_t state_q;
	frame_state_t state_nxt;

	// step outputs
	logic    res_valid;
	result_t res;

	// result register
	logic    out_valid_q;
	result_t out_q;

	logic out_free;   // result register can take a new result this cycle
	logic s1_advance; // byte in input register is consumed this cycle

	assign out_free   = !out_valid_q || out_ch.ready;
	// a byte with no result never waits on the output side
	assign s1_advance = valid_s1 && (out_free || !res_valid);
	assign in_ch.ready = !valid_s1 || s1_advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
		end else if (min_frame_len_we) begin
			min_len_q <= min_frame_len_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

	fed_step u_step (
		.cur       (state_q),
		.raw_byte  (byte_s1),
		.min_len   (min_len_q),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// frame state advances once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_q.out_byte;
	assign out_ch.last     = out_q.last;
	assign out_ch.status   = out_q.status;

endmodule

/* rtl/fed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_checker - port-level assertions for the deframer
// Watches the output channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module fed_checker
	import fed_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last,
	input logic [1:0] status
);

	// non-final bytes always carry a clear status
	a_status_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == STAT_OK)
		else $error("status set on a non-final byte");

	// nothing is offered while reset is held
	a_quiet_in_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(last) && $stable(status))
		else $error("output payload changed while stalled");

endmodule

bind flag_escape_deframer_xor_check fed_checker u_fed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.last      (out_ch.last),
	.status    (out_ch.status)
);

/* dv/flag_escape_deframer_xor_check_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flag_escape_deframer_xor_check_tb - self-checking bench for the deframer
// Feeds raw flag-framed byte streams (clean frames, bad checks, bad escapes,
// doubled flags, escape before flag, noise, saturating frames) under random
// stalls on both channels. A scoreboard predicts every body byte, last flag
// and frame status and compares each output transaction in order.
// ----------------------------------------------------------------------------
module flag_escape_deframer_xor_check_tb
	import fed_pkg::*;
();

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 4;
	localparam int IDLE_PCT      = 27;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_BYTES  = 900;
	localparam int MAX_REPORTS   = 10;

	// frame defects injected by the stream generator
	localparam int FLAW_NONE        = 0;
	localparam int FLAW_XOR         = 1;
	localparam int FLAW_BAD_ESC     = 2;
	localparam int FLAW_ESC_FLAG    = 3;
	localparam int FLAW_DOUBLE_FLAG = 4;

	// ------------------------------------------------------------------
	// Scoreboard: carries its own copy of the deframer state and queues
	// the expected output transaction for every accepted raw byte that yields one.
	// ------------------------------------------------------------------
	class deframe_scoreboard;
		result_t    frames_q[$];
		int         errors;
		logic [7:0] min_len;
		logic [1:0] phase;
		logic [7:0] raw_count;
		logic [7:0] held_byte;
		logic       held_valid;
		logic [7:0] xor_acc;
		logic       escape_error;

		function new();
			errors = 0;
			min_len = MIN_LEN_RESET;
			clear_frame();
			phase = PH_HUNT;
			raw_count = 8'd0;
		endfunction

		function int pending();
			return frames_q.size();
		endfunction

		function void set_min_len(logic [7:0] v);
			min_len = v;
		endfunction

		function void clear_frame();
			held_byte = 8'd0;
			held_valid = 1'b0;
			xor_acc = 8'd0;
			escape_error = 1'b0;
		endfunction

		function void open_frame();
			clear_frame();
			phase = PH_BODY;
			raw_count = 8'd1;
		endfunction

		function void count_raw();
			if (raw_count < RAW_COUNT_MAX)
				raw_count = raw_count + 8'd1;
		endfunction

		// one-byte delay: a new body byte pushes out the held one
		function void take_body(logic [7:0] b);
			result_t r;
			if (held_valid) begin
				r.out_byte = held_byte;
				r.last = 1'b0;
				r.status = STAT_OK;
				frames_q.push_back(r);
				xor_acc = xor_acc ^ held_byte;
			end
			held_byte = b;
			held_valid = 1'b1;
		endfunction

		function void note_input(logic [7:0] b);
			result_t r;
			if (phase != PH_BODY && phase != PH_ESC) begin
				if (b == FLAG_BYTE)
					open_frame();
				return;
			end
			if (b == FLAG_BYTE) begin
				// flag with nothing held: restart the frame
				if (!held_valid) begin
					open_frame();
					return;
				end
				count_raw();
				r.out_byte = held_byte;
				r.last = 1'b1;
				if (escape_error || phase == PH_ESC)
					r.status = STAT_BAD_ESC;
				else if (raw_count < min_len)
					r.status = STAT_SHORT;
				else if (xor_acc != held_byte)
					r.status = STAT_XOR;
				else
					r.status = STAT_OK;
				frames_q.push_back(r);
				clear_frame();
				phase = PH_HUNT;
				raw_count = 8'd0;
				return;
			end
			count_raw();
			if (phase == PH_ESC) begin
				phase = PH_BODY;
				if (b == ESC_FOR_ESC)
					take_body(ESC_BYTE);
				else if (b == ESC_FOR_FLAG)
					take_body(FLAG_BYTE);
				else
					escape_error = 1'b1;
				return;
			end
			if (b == ESC_BYTE) begin
				phase = PH_ESC;
				return;
			end
			take_body(b);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (frames_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected output: byte %02h last %0b status %0d",
						got.out_byte, got.last, got.status);
				return;
			end
			want = frames_q.pop_front();
			if (got.out_byte !== want.out_byte || got.last !== want.last ||
					got.status !== want.status) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"mismatch: expected byte %02h last %0b status %0d,",
						" got byte %02h last %0b status %0d"},
						want.out_byte, want.last, want.status,
						got.out_byte, got.last, got.status);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       min_frame_len_we;
	logic [7:0] min_frame_len_wdata;

	fed_in_if  in_ch();
	fed_out_if out_ch();

	deframe_scoreboard sb;

	// steady: no idling on either side; hold_req: one long sink stall
	bit steady;
	bit hold_req;
	int bytes_taken;
	int noise_bytes;
	int cycles;

	flag_escape_deframer_xor_check i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_ch               (in_ch),
		.out_ch              (out_ch),
		.min_frame_len_we    (min_frame_len_we),
		.min_frame_len_wdata (min_frame_len_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// sink side: random ready, plus one long hold-off counted here so the
	// block backs up into its input while the source keeps offering bytes
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// output monitor: values sampled at the edge are the pre-edge ones
	initial begin
		result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.out_byte = out_ch.out_byte;
				got.last = out_ch.last;
				got.status = out_ch.status;
				sb.check_result(got);
			end
		end
	end

	// Offers one raw byte, with random idle cycles first. Entered and left
	// just after a rising edge; valid stays high into the next transaction.
	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		do
			@(posedge clk);
		while (!(in_ch.valid && in_ch.ready));
		sb.note_input(b);
		bytes_taken++;
	endtask

	// sends a body byte with escape coding applied
	task automatic send_escaped(input logic [7:0] b);
		if (b == FLAG_BYTE) begin
			send_byte(ESC_BYTE);
			send_byte(ESC_FOR_FLAG);
		end else if (b == ESC_BYTE) begin
			send_byte(ESC_BYTE);
			send_byte(ESC_FOR_ESC);
		end else begin
			send_byte(b);
		end
	endtask

	// stop offering, wait out every expected transaction, then let the
	// two-stage pipeline empty of bytes that produce no output
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_len(input logic [7:0] v);
		settle();
		min_frame_len_we <= 1'b1;
		min_frame_len_wdata <= v;
		@(posedge clk);
		min_frame_len_we <= 1'b0;
		sb.set_min_len(v);
	endtask

	// body content biased toward the two codes that need escaping
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return FLAG_BYTE;
		if (r == 1)
			return ESC_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	// one whole frame: opening flag, escaped body, check byte, closing flag
	task automatic send_frame(input int n_body, input int flaw);
		logic [7:0] body[$];
		logic [7:0] chk;
		logic [7:0] b;
		int bad_pos;
		body = {};
		chk = 8'd0;
		for (int i = 0; i < n_body; i++) begin
			b = pick_byte();
			body.push_back(b);
			chk = chk ^ b;
		end
		if (flaw == FLAW_XOR)
			chk = chk ^ 8'($urandom_range(1, 255));
		body.push_back(chk);
		bad_pos = $urandom_range(0, body.size() - 1);
		send_byte(FLAG_BYTE);
		if (flaw == FLAW_DOUBLE_FLAG) begin
			// restart before any body byte; a pending escape is dropped too
			if ($urandom_range(1))
				send_byte(ESC_BYTE);
			send_byte(FLAG_BYTE);
		end
		foreach (body[i]) begin
			if (flaw == FLAW_BAD_ESC && i == bad_pos) begin
				send_byte(ESC_BYTE);
				do
					b = 8'($urandom_range(0, 255));
				while (b == ESC_FOR_ESC || b == ESC_FOR_FLAG || b == FLAG_BYTE);
				send_byte(b);
			end
			send_escaped(body[i]);
		end
		if (flaw == FLAW_ESC_FLAG)
			send_byte(ESC_BYTE);
		send_byte(FLAG_BYTE);
	endtask

	// line noise between frames; a stray flag opens a frame early, which the next flag restarts or closes
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			send_byte(8'($urandom_range(0, 255)));
			noise_bytes++;
		end
	endtask

	initial begin
		int pidx;
		int roll;
		int flaw;
		logic [7:0] len_sel;

		sb = new();
		steady = 1'b0;
		hold_req = 1'b0;
		bytes_taken = 0;
		noise_bytes = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= 8'd0;
		min_frame_len_we <= 1'b0;
		min_frame_len_wdata <= 8'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, reset minimum length of 11 ---
		// bytes while hunting are ignored
		send_byte(8'h00);
		send_byte(8'hff);
		// doubled flag, both escape forms, too short: 7d 7e ff then check fc
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(ESC_BYTE);
		send_byte(ESC_FOR_ESC);
		send_byte(ESC_BYTE);
		send_byte(ESC_FOR_FLAG);
		send_byte(8'hff);
		send_byte(8'hfc);
		send_byte(FLAG_BYTE);
		// bad escape: both bytes dropped, frame flagged
		send_byte(FLAG_BYTE);
		send_byte(ESC_BYTE);
		send_byte(8'h05);
		send_byte(8'h01);
		send_byte(8'h01);
		send_byte(FLAG_BYTE);
		// escape right before the closing flag
		send_byte(FLAG_BYTE);
		send_byte(8'h11);
		send_byte(ESC_BYTE);
		send_byte(FLAG_BYTE);

		// lowest minimum: a clean frame, then a check mismatch
		write_min_len(8'd3);
		send_byte(FLAG_BYTE);
		send_byte(8'h5a);
		send_byte(8'h5a);
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(8'h00);
		send_byte(8'h5b);
		send_byte(FLAG_BYTE);

		// --- random part: phases of frames, new minimum length per phase ---
		noise_bytes = 0;
		bytes_taken = 0;
		pidx = 0;
		while (bytes_taken - noise_bytes < RANDOM_BYTES) begin
			case (pidx % 5)
				0: len_sel = 8'd3;
				1: len_sel = 8'd255;
				2: len_sel = MIN_LEN_RESET;
				default: len_sel = 8'($urandom_range(3, 40));
			endcase
			write_min_len(len_sel);
			// one long stretch with no idling on either side
			steady = (pidx == 2 || pidx == 3);
			if (pidx == 4)
				hold_req = 1'b1;
			// long frames with the largest minimum drive raw_count to its ceiling
			if (pidx == 1 || pidx == 6)
				send_frame($urandom_range(255, 280), FLAW_NONE);
			for (int f = 0; f < 6; f++) begin
				roll = $urandom_range(99);
				if (roll < 70)
					flaw = FLAW_NONE;
				else if (roll < 78)
					flaw = FLAW_XOR;
				else if (roll < 85)
					flaw = FLAW_BAD_ESC;
				else if (roll < 91)
					flaw = FLAW_ESC_FLAG;
				else
					flaw = FLAW_DOUBLE_FLAG;
				send_frame($urandom_range(0, 12), flaw);
				if ($urandom_range(4) == 0)
					send_noise();
			end
			pidx++;
		end
		steady = 1'b0;

		// --- drain and report ---
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/fed_pkg.sv
rtl/fed_in_if.sv
rtl/fed_out_if.sv
rtl/fed_step.sv
rtl/flag_escape_deframer_xor_check.sv
rtl/fed_checker.sv
dv/flag_escape_deframer_xor_check_tb.sv
